[rtl/afc_pkg.sv]
// afc_pkg: shared constants and widths for the bounding box frustum cull
// no dependencies
`timescale 1ns / 1ps

package afc_pkg;

    localparam int COORD_W     = 32;
    localparam int WIDE_W      = COORD_W + 1;
    localparam int PROD_W      = WIDE_W + COORD_W;
    localparam int PAIR_W      = PROD_W + 1;
    localparam int CLIP_W      = PAIR_W + 1;
    localparam int EDGE_W      = CLIP_W + 1;
    localparam int REG_W       = 64;
    localparam int NUM_REGS    = 8;
    localparam int REG_IDX_W   = $clog2(NUM_REGS);
    localparam int NUM_CORNERS = 8;
    localparam int NUM_PLANES  = 6;
    localparam int FRAC_BITS   = 16;

    localparam logic signed [WIDE_W-1:0] MARGIN_Q = WIDE_W'(22938);

    localparam int PL_LEFT   = 0;
    localparam int PL_RIGHT  = 1;
    localparam int PL_BOTTOM = 2;
    localparam int PL_TOP    = 3;
    localparam int PL_NEAR   = 4;
    localparam int PL_FAR    = 5;

    localparam int COL_X = 0;
    localparam int COL_Y = 1;
    localparam int COL_Z = 2;
    localparam int COL_W = 3;

endpackage

[rtl/afc_xform.sv]
// afc_xform: four-stage box widening and corner transform into clip space
// depends on afc_pkg
`timescale 1ns / 1ps

module afc_xform
    import afc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [COORD_W-1:0]     box_min [3],
    input  logic signed [COORD_W-1:0]     box_max [3],
    input  logic        [REG_W-1:0]       coef [NUM_REGS],
    output logic                          clip_valid,
    output logic signed [CLIP_W-1:0]      clip [NUM_CORNERS][4]
);

    logic signed [COORD_W-1:0] mat [4][4];
    logic [3:0]                vld_reg;

    logic signed [WIDE_W-1:0]  lo_reg [3];
    logic signed [WIDE_W-1:0]  hi_reg [3];
    logic signed [PROD_W-1:0]  plo_reg [3][4];
    logic signed [PROD_W-1:0]  phi_reg [3][4];
    logic signed [PAIR_W-1:0]  cst_reg [4];
    logic signed [PAIR_W-1:0]  xy_reg [4][4];
    logic signed [PAIR_W-1:0]  zc_reg [4][2];
    logic signed [CLIP_W-1:0]  clip_reg [NUM_CORNERS][4];

    // row r, column c lives in register 2c + r/2, half r%2
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                mat[r][c] = $signed(coef[2*c + r/2][COORD_W*(r%2) +: COORD_W]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            lo_reg[i] <= WIDE_W'(box_min[i]) - MARGIN_Q;
            hi_reg[i] <= WIDE_W'(box_max[i]) + MARGIN_Q;
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                plo_reg[i][j] <= PROD_W'(lo_reg[i]) * PROD_W'(mat[i][j]);
                phi_reg[i][j] <= PROD_W'(hi_reg[i]) * PROD_W'(mat[i][j]);
            end
        end
        for (int j = 0; j < 4; j++)
        begin
            cst_reg[j] <= PAIR_W'(mat[3][j]) <<< FRAC_BITS;
            for (int k = 0; k < 4; k++)
            begin
                xy_reg[j][k] <= PAIR_W'(k[0] ? phi_reg[0][j] : plo_reg[0][j])
                              + PAIR_W'(k[1] ? phi_reg[1][j] : plo_reg[1][j]);
            end
            zc_reg[j][0] <= PAIR_W'(plo_reg[2][j]) + cst_reg[j];
            zc_reg[j][1] <= PAIR_W'(phi_reg[2][j]) + cst_reg[j];
        end
        for (int c = 0; c < NUM_CORNERS; c++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                clip_reg[c][j] <= CLIP_W'(xy_reg[j][c % 4]) + CLIP_W'(zc_reg[j][c / 4]);
            end
        end
    end

    assign clip_valid = vld_reg[3];
    assign clip       = clip_reg;

endmodule

[rtl/afc_planes.sv]
// afc_planes: per-corner plane tests and the all-corners-outside reduction
// depends on afc_pkg
`timescale 1ns / 1ps

module afc_planes
    import afc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clip_valid,
    input  logic signed [CLIP_W-1:0]      clip [NUM_CORNERS][4],
    output logic                          res_valid,
    output logic [NUM_PLANES-1:0]         res_mask
);

    logic                          vld_reg;
    logic                          res_vld_reg;
    logic [NUM_PLANES-1:0]         out_reg [NUM_CORNERS];
    logic [NUM_PLANES-1:0]         out_next [NUM_CORNERS];
    logic [NUM_PLANES-1:0]         mask_reg;
    logic [NUM_PLANES-1:0]         mask_next;
    logic signed [EDGE_W-1:0]      e_left  [NUM_CORNERS];
    logic signed [EDGE_W-1:0]      e_right [NUM_CORNERS];
    logic signed [EDGE_W-1:0]      e_bot   [NUM_CORNERS];
    logic signed [EDGE_W-1:0]      e_top   [NUM_CORNERS];
    logic signed [EDGE_W-1:0]      e_far   [NUM_CORNERS];

    always_comb
    begin
        for (int c = 0; c < NUM_CORNERS; c++)
        begin
            e_left[c]  = EDGE_W'(clip[c][COL_X]) + EDGE_W'(clip[c][COL_W]);
            e_right[c] = EDGE_W'(clip[c][COL_X]) - EDGE_W'(clip[c][COL_W]);
            e_bot[c]   = EDGE_W'(clip[c][COL_Y]) + EDGE_W'(clip[c][COL_W]);
            e_top[c]   = EDGE_W'(clip[c][COL_Y]) - EDGE_W'(clip[c][COL_W]);
            e_far[c]   = EDGE_W'(clip[c][COL_Z]) - EDGE_W'(clip[c][COL_W]);
            out_next[c][PL_LEFT]   = e_left[c] < 0;
            out_next[c][PL_RIGHT]  = e_right[c] > 0;
            out_next[c][PL_BOTTOM] = e_bot[c] < 0;
            out_next[c][PL_TOP]    = e_top[c] > 0;
            out_next[c][PL_NEAR]   = clip[c][COL_Z] < 0;
            out_next[c][PL_FAR]    = e_far[c] > 0;
        end
        mask_next = '1;
        for (int c = 0; c < NUM_CORNERS; c++)
        begin
            mask_next = mask_next & out_reg[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg     <= clip_valid;
            res_vld_reg <= vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        mask_reg <= mask_next;
    end

    assign res_valid = res_vld_reg;
    assign res_mask  = mask_reg;

endmodule

[rtl/aabb_frustum_cull.sv]
// aabb_frustum_cull: top level, configuration registers and pipeline wiring
// depends on afc_pkg, afc_xform, afc_planes
`timescale 1ns / 1ps

// usage
// - write the eight matrix registers through wr_en / wr_index / wr_data while idle
// - present a box on the box_* ports with start high; busy is always low, so a
//   transfer happens on every cycle that start is high
// - after the transfer, done pulses for one cycle with visible and
//   reject_mask valid; the receiver cannot stall
// - throughput is one box per cycle; each box passes through the widen,
//   multiply, two adder and two plane-test stages
// - reset clears the pipeline valid bits and all matrix registers to zero
// - results leave in the order boxes arrive, one result per box
module aabb_frustum_cull
    import afc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [COORD_W-1:0]  box_min_x,
    input  logic signed [COORD_W-1:0]  box_min_y,
    input  logic signed [COORD_W-1:0]  box_min_z,
    input  logic signed [COORD_W-1:0]  box_max_x,
    input  logic signed [COORD_W-1:0]  box_max_y,
    input  logic signed [COORD_W-1:0]  box_max_z,
    input  logic                       wr_en,
    input  logic [REG_IDX_W-1:0]       wr_index,
    input  logic [REG_W-1:0]           wr_data,
    output logic                       done,
    output logic                       visible,
    output logic [NUM_PLANES-1:0]      reject_mask
);

    logic [REG_W-1:0]           coef_reg [NUM_REGS];
    logic signed [COORD_W-1:0]  bmin [3];
    logic signed [COORD_W-1:0]  bmax [3];
    logic                       clip_valid;
    logic signed [CLIP_W-1:0]   clip [NUM_CORNERS][4];
    logic                       res_valid;
    logic [NUM_PLANES-1:0]      res_mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            coef_reg[wr_index] <= wr_data;
        end
    end

    assign bmin[0] = box_min_x;
    assign bmin[1] = box_min_y;
    assign bmin[2] = box_min_z;
    assign bmax[0] = box_max_x;
    assign bmax[1] = box_max_y;
    assign bmax[2] = box_max_z;

    afc_xform u_xform (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start),
        .box_min    (bmin),
        .box_max    (bmax),
        .coef       (coef_reg),
        .clip_valid (clip_valid),
        .clip       (clip)
    );

    afc_planes u_planes (
        .clk        (clk),
        .rst_n      (rst_n),
        .clip_valid (clip_valid),
        .clip       (clip),
        .res_valid  (res_valid),
        .res_mask   (res_mask)
    );

    assign busy        = 1'b0;
    assign done        = res_valid;
    assign reject_mask = res_mask;
    assign visible     = (res_mask == '0);

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##6 done)
        else $error("transfer did not produce a result six cycles later");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 6))
        else $error("result without a matching transfer");

    a_vis: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (visible == (reject_mask == '0)))
        else $error("visible disagrees with reject mask");

endmodule

[verif/aabb_frustum_cull_tb.sv]
// aabb_frustum_cull_tb: self-checking testbench for the bounding box frustum cull
// predicts visibility and plane rejects in exact wide arithmetic; depends on afc_pkg
`timescale 1ns / 1ps

class cull_scoreboard;
    logic [5:0] pending_masks[$];
    int         errors;
    int         checked;

    function new();
        errors  = 0;
        checked = 0;
    endfunction

    function void note_box(logic [5:0] mask);
        pending_masks = {pending_masks, mask};
    endfunction

    function void check_result(logic vis, logic [5:0] mask);
        logic [5:0] exp_mask;
        if (pending_masks.size() == 0)
        begin
            $display("%0t: unexpected result visible=%0b mask=%0h", $time, vis, mask);
            errors++;
            return;
        end
        exp_mask = pending_masks.pop_front();
        checked++;
        if (vis !== (exp_mask == 6'd0))
        begin
            $display("%0t: visible expected %0b actual %0b", $time, exp_mask == 6'd0, vis);
            errors++;
        end
        if (mask !== exp_mask)
        begin
            $display("%0t: reject_mask expected %0h actual %0h", $time, exp_mask, mask);
            errors++;
        end
    endfunction
endclass

module aabb_frustum_cull_tb;
    import afc_pkg::*;

    localparam int IDX_XA = 0;
    localparam int IDX_XB = 1;
    localparam int IDX_YA = 2;
    localparam int IDX_YB = 3;
    localparam int IDX_ZA = 4;
    localparam int IDX_ZB = 5;
    localparam int IDX_WA = 6;
    localparam int IDX_WB = 7;
    localparam int LATENCY = 6;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [31:0] box_min_x = '0, box_min_y = '0, box_min_z = '0;
    logic signed [31:0] box_max_x = '0, box_max_y = '0, box_max_z = '0;
    logic wr_en = 1'b0;
    logic [REG_IDX_W-1:0] wr_index = '0;
    logic [63:0] wr_data = '0;
    logic done;
    logic visible;
    logic [5:0] reject_mask;

    logic [63:0] matrix_regs[8];
    cull_scoreboard sb;
    int send_idle_pct;
    int boxes_sent;

    aabb_frustum_cull u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .box_min_x(box_min_x), .box_min_y(box_min_y), .box_min_z(box_min_z),
        .box_max_x(box_max_x), .box_max_y(box_max_y), .box_max_z(box_max_z),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .done(done), .visible(visible), .reject_mask(reject_mask)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic signed [63:0] entry(int row, int col);
        logic [63:0] r;
        r = matrix_regs[2 * col + row / 2];
        return (row % 2) ? $signed(r[63:32]) : $signed(r[31:0]);
    endfunction

    function automatic logic [5:0] cull_mask(logic signed [31:0] mn[3], logic signed [31:0] mx[3]);
        logic signed [127:0] lo[3], hi[3], p[4], c[4];
        int cnt[6];
        logic [5:0] m;
        for (int i = 0; i < 6; i++)
            cnt[i] = 0;
        for (int i = 0; i < 3; i++)
        begin
            lo[i] = 128'(mn[i]) - 128'sd22938;
            hi[i] = 128'(mx[i]) + 128'sd22938;
        end
        for (int k = 0; k < 8; k++)
        begin
            for (int i = 0; i < 3; i++)
                p[i] = ((k >> i) & 1) ? hi[i] : lo[i];
            p[3] = 128'sd65536;
            for (int j = 0; j < 4; j++)
            begin
                c[j] = 0;
                for (int i = 0; i < 4; i++)
                    c[j] += p[i] * 128'(entry(i, j));
            end
            if (c[0] + c[3] < 0) cnt[PL_LEFT]++;
            if (c[0] - c[3] > 0) cnt[PL_RIGHT]++;
            if (c[1] + c[3] < 0) cnt[PL_BOTTOM]++;
            if (c[1] - c[3] > 0) cnt[PL_TOP]++;
            if (c[2] < 0) cnt[PL_NEAR]++;
            if (c[2] - c[3] > 0) cnt[PL_FAR]++;
        end
        for (int i = 0; i < 6; i++)
            m[i] = (cnt[i] == 8);
        return m;
    endfunction

    always @(posedge clk)
        if (rst_n && done)
            sb.check_result(visible, reject_mask);

    task automatic write_reg(int idx, logic [63:0] val);
        wr_en    <= 1'b1;
        wr_index <= REG_IDX_W'(idx);
        wr_data  <= val;
        matrix_regs[idx] = val;
        @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending_masks.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    function automatic logic [63:0] pack(int lo_q, int hi_q);
        return {32'(hi_q), 32'(lo_q)};
    endfunction

    task automatic load_matrix(int kind);
        logic [63:0] v[8];
        case (kind)
            0: for (int i = 0; i < 8; i++) v[i] = '0;
            1:
            begin
                // identity, z in 0..w
                v[IDX_XA] = pack(65536, 0); v[IDX_XB] = pack(0, 0);
                v[IDX_YA] = pack(0, 65536); v[IDX_YB] = pack(0, 0);
                v[IDX_ZA] = pack(0, 0);     v[IDX_ZB] = pack(65536, 0);
                v[IDX_WA] = pack(0, 0);     v[IDX_WB] = pack(0, 65536);
            end
            2:
            begin
                // perspective-like, w from -z
                v[IDX_XA] = pack(80000, 0);  v[IDX_XB] = pack(0, 0);
                v[IDX_YA] = pack(0, 100000); v[IDX_YB] = pack(0, 0);
                v[IDX_ZA] = pack(0, 0);      v[IDX_ZB] = pack(-65600, 6553);
                v[IDX_WA] = pack(0, 0);      v[IDX_WB] = pack(-65536, 0);
            end
            3: for (int i = 0; i < 8; i++) v[i] = {2{32'h8000_0000}};
            4: for (int i = 0; i < 8; i++) v[i] = {2{32'h7fff_ffff}};
            5: for (int i = 0; i < 8; i++) v[i] = 64'hffff_ffff_ffff_ffff;
            default:
                for (int i = 0; i < 8; i++)
                    v[i] = {32'($urandom_range(0, 262143) - 131072),
                            32'($urandom_range(0, 262143) - 131072)};
        endcase
        for (int i = 0; i < 8; i++)
            write_reg(i, v[i]);
        wr_en <= 1'b0;
    endtask

    task automatic send_box(logic signed [31:0] mn[3], logic signed [31:0] mx[3]);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        box_min_x <= mn[0]; box_min_y <= mn[1]; box_min_z <= mn[2];
        box_max_x <= mx[0]; box_max_y <= mx[1]; box_max_z <= mx[2];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_box(cull_mask(mn, mx));
        boxes_sent++;
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 32'($urandom());
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            default: return 32'($urandom_range(0, 20 * 65536)) - 32'sd655360;
        endcase
    endfunction

    task automatic random_boxes(int n);
        logic signed [31:0] mn[3], mx[3], t;
        for (int k = 0; k < n; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mn[i] = rand_coord();
                mx[i] = rand_coord();
                if ($urandom_range(0, 9) != 0 && mn[i] > mx[i])
                begin
                    t = mn[i]; mn[i] = mx[i]; mx[i] = t;
                end
            end
            if (k == n / 2)
                drain();
            send_box(mn, mx);
        end
    endtask

    task automatic directed_boxes();
        logic signed [31:0] mn[3], mx[3];
        int vals[6] = '{32'h8000_0000, 32'h7fff_ffff, 0, -22938, 65536, -65536};
        for (int a = 0; a < 6; a++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mn[i] = vals[a];
                mx[i] = vals[(a + 1) % 6];
            end
            send_box(mn, mx);
        end
        // box sitting on a plane after widening
        for (int i = 0; i < 3; i++)
        begin
            mn[i] = 65536 + 22938;
            mx[i] = 3 * 65536;
        end
        send_box(mn, mx);
        for (int i = 0; i < 3; i++)
        begin
            mn[i] = -3 * 65536;
            mx[i] = -65536 - 22938;
        end
        send_box(mn, mx);
    endtask

    initial
    begin
        #200000;
        $display("timeout");
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        sb = new();
        boxes_sent = 0;
        send_idle_pct = 22;
        for (int i = 0; i < 8; i++)
            matrix_regs[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_boxes();
        drain();
        for (int kind = 1; kind <= 6; kind++)
        begin
            load_matrix(kind);
            directed_boxes();
            drain();
        end
        for (int ph = 0; ph < 9; ph++)
        begin
            send_idle_pct = (ph < 3) ? 22 : (ph < 6) ? 75 : 0;
            load_matrix((ph % 3 == 0) ? 2 : 6);
            random_boxes(100);
            drain();
        end
        drain();
        $display("sent %0d boxes over %0d matrix settings, %0d results checked",
                 boxes_sent, 16, sb.checked);
        if (sb.errors == 0 && sb.pending_masks.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
